// ----- design/partition_window_scheduler_top_macros.svh -----
// assertion macros for the partition window scheduler
`ifndef PARTITION_WINDOW_SCHEDULER_TOP_MACROS_SVH
`define PARTITION_WINDOW_SCHEDULER_TOP_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication, sampled on clk, off during reset
`define PWS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pws assertion failed");
// next-cycle implication, sampled on clk, off during reset
`define PWS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pws assertion failed");
`else
`define PWS_ASSERT_IMP(label, ante, cons)
`define PWS_ASSERT_NXT(label, ante, cons)
`endif

`endif

// ----- design/pws_pkg.sv -----
// shared types and constants of the partition window scheduler
package pws_pkg;

  // parameter defaults
  localparam int WINDOW_COUNT_DEF   = 16;
  localparam int PARTITION_BITS_DEF = 4;
  localparam int TIME_BITS_DEF      = 16;

  // fixed field widths of the channels
  localparam int REQ_IDX_W  = 4;
  localparam int REQ_TIME_W = 16;
  localparam int REQ_PART_W = 4;
  localparam int OUT_PART_W = 4;
  localparam int OUT_WIN_W  = 4;
  localparam int CFG_W      = 16;

  localparam logic [CFG_W-1:0] FRAME_LENGTH_RST = 16'd1000;

  // request codes
  typedef enum logic {
    REQ_TICK  = 1'b0,
    REQ_WRITE = 1'b1
  } req_type_t;

  // sequencer states
  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_LOAD,
    ST_DONE
  } pws_state_t;

  // one tick result
  typedef struct packed {
    logic [OUT_PART_W-1:0] active_partition;
    logic [OUT_WIN_W-1:0]  active_window;
    logic                  window_changed;
    logic                  schedule_error;
  } pws_result_t;

endpackage

// ----- design/pws_req_if.sv -----
// request channel: ticks and window table writes
interface pws_req_if;
  import pws_pkg::*;

  logic                  valid;
  logic                  ready;
  logic                  req_type;
  logic [REQ_IDX_W-1:0]  entry_index;
  logic [REQ_TIME_W-1:0] entry_start;
  logic [REQ_TIME_W-1:0] entry_duration;
  logic [REQ_PART_W-1:0] entry_partition;
  logic                  entry_valid;

  modport source (
    output valid, req_type, entry_index, entry_start, entry_duration,
           entry_partition, entry_valid,
    input  ready
  );

  modport sink (
    input  valid, req_type, entry_index, entry_start, entry_duration,
           entry_partition, entry_valid,
    output ready
  );
endinterface

// ----- design/pws_rsp_if.sv -----
// result channel: active partition per tick
interface pws_rsp_if;
  import pws_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [OUT_PART_W-1:0] active_partition;
  logic [OUT_WIN_W-1:0]  active_window;
  logic                  window_changed;
  logic                  schedule_error;

  modport source (
    output valid, active_partition, active_window, window_changed, schedule_error,
    input  ready
  );

  modport sink (
    input  valid, active_partition, active_window, window_changed, schedule_error,
    output ready
  );
endinterface

// ----- design/partition_window_scheduler_top.sv -----
// top level of the partition window scheduler
//
//  port       | dir | contents
//  -----------+-----+-----------------------------------------------------
//  in_req     | in  | tick or window table write, valid/ready transaction
//  out_rsp    | out | active partition per tick, valid/ready transaction
//  cfg_we     | in  | frame length write strobe, data on cfg_wdata
//
//  a table write completes in idle; a tick that stays in its window goes from idle to done
//  a tick that changes window goes through scan, load and done, skipping unused entries:
//  the walk tests one used mark per cycle, then waits in load on the table ram read
//  reset is synchronous active low; it clears used marks, position and current window
//  the output register takes the next result only when it is empty or out_rsp takes its result
`include "partition_window_scheduler_top_macros.svh"

module partition_window_scheduler_top #(
  parameter int WINDOW_COUNT   = pws_pkg::WINDOW_COUNT_DEF,
  parameter int PARTITION_BITS = pws_pkg::PARTITION_BITS_DEF,
  parameter int TIME_BITS      = pws_pkg::TIME_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_we,
  input  logic [pws_pkg::CFG_W-1:0] cfg_wdata,
  pws_req_if.sink                   in_req,
  pws_rsp_if.source                 out_rsp
);
  import pws_pkg::*;

  logic [CFG_W-1:0] frame_length_r;
  logic             res_valid;
  logic             res_ready;
  pws_result_t      res;
  logic             out_valid_r, out_valid_nxt;
  pws_result_t      out_r;

  // frame length register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_length_r <= FRAME_LENGTH_RST;
    end else if (cfg_we) begin
      frame_length_r <= cfg_wdata;
    end
  end

  pws_ctrl #(
    .WINDOW_COUNT  (WINDOW_COUNT),
    .PARTITION_BITS(PARTITION_BITS),
    .TIME_BITS     (TIME_BITS)
  ) u_ctrl (
    .clk         (clk),
    .rst_n       (rst_n),
    .frame_length(frame_length_r),
    .in_req      (in_req),
    .res_valid   (res_valid),
    .res_ready   (res_ready),
    .res         (res)
  );

  // output register stage
  assign res_ready = !out_valid_r || out_rsp.ready;

  always_comb begin
    out_valid_nxt = out_valid_r;
    if (res_valid && res_ready) begin
      out_valid_nxt = 1'b1;
    end else if (out_rsp.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (res_valid && res_ready) begin
      out_r <= res;
    end
  end

  assign out_rsp.valid            = out_valid_r;
  assign out_rsp.active_partition = out_r.active_partition;
  assign out_rsp.active_window    = out_r.active_window;
  assign out_rsp.window_changed   = out_r.window_changed;
  assign out_rsp.schedule_error   = out_r.schedule_error;

  // an error reports partition zero and no window change
  `PWS_ASSERT_IMP(a_err_clean, out_valid_r && out_rsp.schedule_error, (out_rsp.active_partition == '0) && !out_rsp.window_changed)
  // a change and an error never come together from the sequencer
  `PWS_ASSERT_IMP(a_res_excl, res_valid, !(res.window_changed && res.schedule_error))
  // an accepted tick blocks the input until its result is handed over
  `PWS_ASSERT_NXT(a_tick_busy, in_req.valid && in_req.ready && (in_req.req_type == REQ_TICK), !in_req.ready)

endmodule

// ----- design/pws_ram.sv -----
// generic single write port ram with registered read
module pws_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- design/pws_ctrl.sv -----
// window table, used marks and the tick sequencer that walks the table
module pws_ctrl #(
  parameter int WINDOW_COUNT   = pws_pkg::WINDOW_COUNT_DEF,
  parameter int PARTITION_BITS = pws_pkg::PARTITION_BITS_DEF,
  parameter int TIME_BITS      = pws_pkg::TIME_BITS_DEF
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic [pws_pkg::CFG_W-1:0] frame_length,
  pws_req_if.sink                   in_req,
  output logic                      res_valid,
  input  logic                      res_ready,
  output pws_pkg::pws_result_t      res
);
  import pws_pkg::*;

  localparam int IDX_W   = $clog2(WINDOW_COUNT);
  localparam int SCAN_W  = $clog2(WINDOW_COUNT + 1);
  localparam int STOP_W  = TIME_BITS + 1;
  localparam int ENTRY_W = 2 * TIME_BITS + PARTITION_BITS;

  pws_state_t              state_r, state_nxt;
  logic [WINDOW_COUNT-1:0] used_r;
  logic [TIME_BITS-1:0]    pos_r, pos_nxt;
  logic [IDX_W-1:0]        cur_r, cur_nxt;
  logic                    none_r, none_nxt;
  logic [STOP_W-1:0]       stop_r, stop_nxt;
  logic [PARTITION_BITS-1:0] owner_r, owner_nxt;
  logic [SCAN_W-1:0]       scan_r, scan_nxt;
  logic                    changed_r, changed_nxt;
  logic                    err_r, err_nxt;

  logic                    accept;
  logic                    wr_hit;
  logic [IDX_W-1:0]        waddr;
  logic [ENTRY_W-1:0]      wdata;
  logic                    ram_re;
  logic [ENTRY_W-1:0]      rdata;
  logic [TIME_BITS-1:0]    len_raw, len, pos;
  logic [STOP_W-1:0]       pos_inc;
  logic                    advance;
  logic [TIME_BITS-1:0]    rd_start, rd_dur;
  logic [PARTITION_BITS-1:0] rd_owner;

  assign accept = in_req.valid && in_req.ready;
  assign in_req.ready = (state_r == ST_IDLE);

  // table write decode, indexes beyond the table are dropped
  assign wr_hit = accept && (in_req.req_type == REQ_WRITE) &&
                  (32'(in_req.entry_index) < WINDOW_COUNT);
  assign waddr  = IDX_W'(in_req.entry_index);
  assign wdata  = {TIME_BITS'(in_req.entry_start), TIME_BITS'(in_req.entry_duration),
                   PARTITION_BITS'(in_req.entry_partition)};

  pws_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(WINDOW_COUNT)
  ) u_table (
    .clk  (clk),
    .we   (wr_hit),
    .waddr(waddr),
    .wdata(wdata),
    .re   (ram_re),
    .raddr(scan_r[IDX_W-1:0]),
    .rdata(rdata)
  );

  assign rd_start = rdata[ENTRY_W-1 -: TIME_BITS];
  assign rd_dur   = rdata[PARTITION_BITS +: TIME_BITS];
  assign rd_owner = rdata[PARTITION_BITS-1:0];

  // used marks, cleared by reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (wr_hit) begin
      used_r[waddr] <= in_req.entry_valid;
    end
  end

  // frame position of this tick and the position after it
  always_comb begin
    len_raw = TIME_BITS'(frame_length);
    len     = (len_raw == '0) ? TIME_BITS'(1) : len_raw;
    pos     = (pos_r >= len) ? '0 : pos_r;
    pos_inc = STOP_W'(pos) + STOP_W'(1);
    advance = (pos == '0) || (stop_r <= STOP_W'(pos));
  end

  // sequencer next state
  always_comb begin
    state_nxt   = state_r;
    pos_nxt     = pos_r;
    cur_nxt     = cur_r;
    none_nxt    = none_r;
    stop_nxt    = stop_r;
    owner_nxt   = owner_r;
    scan_nxt    = scan_r;
    changed_nxt = changed_r;
    err_nxt     = err_r;
    ram_re      = 1'b0;
    res_valid   = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_req.req_type == REQ_TICK)) begin
          pos_nxt     = (pos_inc >= STOP_W'(len)) ? '0 : pos_inc[TIME_BITS-1:0];
          changed_nxt = 1'b0;
          err_nxt     = 1'b0;
          if (advance) begin
            if (pos == '0) begin
              none_nxt = 1'b1;
            end
            scan_nxt  = ((pos == '0) || none_r) ? '0 : SCAN_W'(cur_r) + SCAN_W'(1);
            state_nxt = ST_SCAN;
          end else begin
            state_nxt = ST_DONE;
          end
        end
      end
      ST_SCAN: begin
        if (scan_r == SCAN_W'(WINDOW_COUNT)) begin
          // no used window left
          stop_nxt  = '0;
          owner_nxt = '0;
          err_nxt   = 1'b1;
          state_nxt = ST_DONE;
        end else if (used_r[scan_r[IDX_W-1:0]]) begin
          ram_re    = 1'b1;
          cur_nxt   = scan_r[IDX_W-1:0];
          none_nxt  = 1'b0;
          state_nxt = ST_LOAD;
        end else begin
          scan_nxt = scan_r + SCAN_W'(1);
        end
      end
      ST_LOAD: begin
        stop_nxt    = STOP_W'(rd_start) + STOP_W'(rd_dur);
        owner_nxt   = rd_owner;
        changed_nxt = 1'b1;
        state_nxt   = ST_DONE;
      end
      ST_DONE: begin
        res_valid = 1'b1;
        if (res_ready) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // sequencer registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      pos_r     <= '0;
      cur_r     <= '0;
      none_r    <= 1'b1;
      stop_r    <= '0;
      owner_r   <= '0;
      scan_r    <= '0;
      changed_r <= 1'b0;
      err_r     <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      pos_r     <= pos_nxt;
      cur_r     <= cur_nxt;
      none_r    <= none_nxt;
      stop_r    <= stop_nxt;
      owner_r   <= owner_nxt;
      scan_r    <= scan_nxt;
      changed_r <= changed_nxt;
      err_r     <= err_nxt;
    end
  end

  // tick result
  always_comb begin
    res.active_partition = err_r ? '0 : OUT_PART_W'(owner_r);
    res.active_window    = none_r ? '0 : OUT_WIN_W'(cur_r);
    res.window_changed   = changed_r;
    res.schedule_error   = err_r;
  end

endmodule
